// ===== hw/rtl/swps_pkg.sv =====
`timescale 1ns / 1ps

package swps_pkg;

  localparam int LANES      = 4;
  localparam int WORD_LANES = 4;
  localparam int USED_LANES = (LANES < WORD_LANES) ? LANES : WORD_LANES;
  localparam int LANE_W     = 16;
  localparam int WORD_W     = 64;
  localparam int REG_W      = 16;
  localparam int SQ_W       = 15;   // (127)^2 and (-128)^2 fit in 15 bits

  localparam logic [REG_W-1:0] SPATIAL_TOL_RST  = 16'd600;
  localparam logic [REG_W-1:0] TEMPORAL_TOL_RST = 16'd300;
  localparam logic [REG_W-1:0] SIM_THRESH_RST   = 16'd25;

  typedef enum logic [1:0] {
    REG_SPATIAL_TOL  = 2'd0,
    REG_TEMPORAL_TOL = 2'd1,
    REG_SIM_THRESH   = 2'd2,
    REG_UNUSED       = 2'd3
  } swps_reg_idx_t;

  // pipeline advance enables shared by all lanes
  typedef struct packed {
    logic en_a;
    logic en_b;
  } swps_adv_t;

endpackage

// ===== hw/rtl/similarity_weave_pixel_select.sv =====
`timescale 1ns / 1ps
// Adaptive weave/bob pixel selector for deinterlacing.
// Input channel (in_*): one request per group of four YUYV 16-bit lanes, carrying
// the line above, the current line from the other field, the line below and the
// same line two fields earlier. Output channel (out_*): one 64-bit word per
// request, each lane either the current lane (weave) or the per-byte average of
// the lines above and below (bob).
// Config channel (cfg_*): index 0 spatial tolerance, 1 temporal tolerance,
// 2 signed similarity threshold, 3 ignored; always ready, write only when idle.
// Throughput: one request per clock when the output is not stalled, set by the
// four lanes working in parallel. An accepted request passes the squares stage,
// the decision stage and the output register, in that order.
// Reset (rst_n low, synchronous) empties the pipeline and loads the tolerances
// 600 / 300 and threshold 25.
// When out_tready is low the result is held and a skid register takes one more;
// in_tready then drops only once both pipeline stages and the skid are full.
module similarity_weave_pixel_select (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // [63:0] above_word, [127:64] current_word, [191:128] below_word,
  // [255:192] older_word
  input  logic [255:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // [63:0] out_word
  output logic [63:0]  out_tdata,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [15:0]  cfg_data
);
  import swps_pkg::*;

  logic [REG_W-1:0] spatial_tol_r, temporal_tol_r, sim_thresh_r;
  logic             va_r, vb_r;
  logic             can_push;
  swps_adv_t        adv;
  logic [WORD_W-1:0] above_word, current_word, below_word, older_word;
  logic [USED_LANES-1:0][LANE_W-1:0] lane_res;

  assign above_word   = in_tdata[63:0];
  assign current_word = in_tdata[127:64];
  assign below_word   = in_tdata[191:128];
  assign older_word   = in_tdata[255:192];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spatial_tol_r  <= SPATIAL_TOL_RST;
      temporal_tol_r <= TEMPORAL_TOL_RST;
      sim_thresh_r   <= SIM_THRESH_RST;
    end else if (cfg_valid) begin
      unique case (swps_reg_idx_t'(cfg_index))
        REG_SPATIAL_TOL:  spatial_tol_r  <= cfg_data;
        REG_TEMPORAL_TOL: temporal_tol_r <= cfg_data;
        REG_SIM_THRESH:   sim_thresh_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // a stage moves when the one after it has room
  assign adv.en_b  = !vb_r || can_push;
  assign adv.en_a  = !va_r || adv.en_b;
  assign in_tready = adv.en_a;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
    end else begin
      if (adv.en_a) va_r <= in_tvalid;
      if (adv.en_b) vb_r <= va_r;
    end
  end

  for (genvar k = 0; k < USED_LANES; k++) begin : g_lane
    swps_lane u_lane (
      .clk          (clk),
      .adv          (adv),
      .above_lane   (above_word[k*LANE_W +: LANE_W]),
      .current_lane (current_word[k*LANE_W +: LANE_W]),
      .below_lane   (below_word[k*LANE_W +: LANE_W]),
      .older_lane   (older_word[k*LANE_W +: LANE_W]),
      .spatial_tol  (spatial_tol_r),
      .temporal_tol (temporal_tol_r),
      .sim_thresh   (sim_thresh_r),
      .lane_out     (lane_res[k])
    );
  end

  swps_merge u_merge (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (vb_r && can_push),
    .lane_res   (lane_res),
    .can_push   (can_push),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

`ifndef SYNTHESIS
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (va_r && vb_r && !can_push))
    else $error("input stalled with room in the pipeline");

  a_spatial_write: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_valid && cfg_index == REG_SPATIAL_TOL) |=> (spatial_tol_r == $past(cfg_data)))
    else $error("spatial tolerance write lost");

  a_thresh_write: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_valid && cfg_index == REG_SIM_THRESH) |=> (sim_thresh_r == $past(cfg_data)))
    else $error("threshold write lost");
`endif

endmodule

// ===== hw/rtl/swps_lane.sv =====
`timescale 1ns / 1ps

module swps_lane (
  input  logic                        clk,
  input  swps_pkg::swps_adv_t         adv,
  input  logic [swps_pkg::LANE_W-1:0] above_lane,
  input  logic [swps_pkg::LANE_W-1:0] current_lane,
  input  logic [swps_pkg::LANE_W-1:0] below_lane,
  input  logic [swps_pkg::LANE_W-1:0] older_lane,
  input  logic [swps_pkg::REG_W-1:0]  spatial_tol,
  input  logic [swps_pkg::REG_W-1:0]  temporal_tol,
  input  logic [swps_pkg::REG_W-1:0]  sim_thresh,
  output logic [swps_pkg::LANE_W-1:0] lane_out
);
  import swps_pkg::*;

  function automatic logic [SQ_W-1:0] half_sq(input logic [7:0] a, input logic [7:0] b);
    logic signed [9:0]  diff;
    logic signed [9:0]  half;
    logic signed [8:0]  h;
    logic signed [17:0] p;
    diff = $signed({2'b00, a}) - $signed({2'b00, b});
    half = diff >>> 1;
    h    = half[8:0];
    p    = h * h;
    return p[SQ_W-1:0];
  endfunction

  function automatic logic [REG_W-1:0] sub_floor0(input logic [REG_W-1:0] tol,
                                                  input logic [SQ_W-1:0] sq);
    logic [REG_W-1:0] sq_ext;
    sq_ext = {1'b0, sq};
    return (tol > sq_ext) ? (tol - sq_ext) : '0;
  endfunction

  function automatic logic [REG_W-1:0] add_sat(input logic [REG_W-1:0] a,
                                               input logic [REG_W-1:0] b);
    logic [REG_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[REG_W] ? {REG_W{1'b1}} : s[REG_W-1:0];
  endfunction

  // stage A: squared half differences, bob average, current lane
  logic [SQ_W-1:0]   sq1_r, sq2_r, sq3_r;
  logic [LANE_W-1:0] cur_r, bob_r;
  logic [LANE_W-1:0] bob_nxt;

  assign bob_nxt = {(above_lane[15:8] >> 1) + (below_lane[15:8] >> 1),
                    (above_lane[7:0] >> 1) + (below_lane[7:0] >> 1)};

  always_ff @(posedge clk) begin
    if (adv.en_a) begin
      sq1_r <= half_sq(above_lane[7:0], current_lane[7:0]);
      sq2_r <= half_sq(below_lane[7:0], current_lane[7:0]);
      sq3_r <= half_sq(older_lane[7:0], current_lane[7:0]);
      cur_r <= current_lane;
      bob_r <= bob_nxt;
    end
  end

  // stage B: similarity sum and weave/bob decision
  logic [REG_W-1:0]  sim_sum;
  logic              weave;
  logic [LANE_W-1:0] lane_r, lane_nxt;

  always_comb begin
    sim_sum  = add_sat(add_sat(sub_floor0(spatial_tol, sq1_r),
                               sub_floor0(spatial_tol, sq2_r)),
                       sub_floor0(temporal_tol, sq3_r));
    weave    = $signed(sim_sum) > $signed(sim_thresh);
    lane_nxt = weave ? cur_r : bob_r;
  end

  always_ff @(posedge clk) begin
    if (adv.en_b) begin
      lane_r <= lane_nxt;
    end
  end

  assign lane_out = lane_r;

endmodule

// ===== hw/rtl/swps_merge.sv =====
`timescale 1ns / 1ps

module swps_merge (
  input  logic                                            clk,
  input  logic                                            rst_n,
  input  logic                                            push,
  input  logic [swps_pkg::USED_LANES-1:0][swps_pkg::LANE_W-1:0] lane_res,
  output logic                                            can_push,
  output logic                                            out_tvalid,
  input  logic                                            out_tready,
  output logic [swps_pkg::WORD_W-1:0]                     out_tdata
);
  import swps_pkg::*;

  logic [WORD_W-1:0] word;
  logic [WORD_W-1:0] out_data_r, skid_data_r;
  logic              out_valid_r, skid_valid_r;

  // lanes past the used ones stay zero
  always_comb begin
    word = '0;
    for (int k = 0; k < USED_LANES; k++) begin
      word[k*LANE_W +: LANE_W] = lane_res[k];
    end
  end

  assign can_push = !skid_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || out_tready) begin
      if (skid_valid_r) begin
        out_data_r   <= skid_data_r;
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else if (push) begin
        out_data_r  <= word;
        out_valid_r <= 1'b1;
      end else begin
        out_valid_r <= 1'b0;
      end
    end else if (push) begin
      skid_data_r  <= word;
      skid_valid_r <= 1'b1;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

`ifndef SYNTHESIS
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry held without an output request");

  a_stall_fills_skid: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tready && push) |=> skid_valid_r)
    else $error("request pushed during stall was dropped");

  a_drain_empties: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_tready && !skid_valid_r && !push) |=> !out_valid_r)
    else $error("output request repeated");
`endif

endmodule
